>>> rtl/otsu_pkg.sv
// Package for the Otsu threshold core: default sizes, field widths,
// sequencer and multiply-step enums, histogram command struct.
// No dependencies.
`default_nettype none
package otsu_pkg;

    localparam int GRAY_LEVELS_DEF      = 256;
    localparam int PIXEL_COUNT_BITS_DEF = 20;
    localparam int PIX_W                = 8;
    localparam int THR_W                = 8;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_ACC,
        ST_DRAIN,
        ST_RD,
        ST_HV,
        ST_MADD,
        ST_MSTART,
        ST_MWAIT,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_MW,
        OP_MN,
        OP_DD,
        OP_WB,
        OP_X1,
        OP_X2
    } t_op;

    typedef struct packed {
        logic inc;
        logic wz;
    } t_hist_cmd;

endpackage
`default_nettype wire

>>> rtl/otsu_if.sv
// Valid/ready channels of the Otsu core: pixel beats in, threshold beats out.
// Depends on otsu_pkg.
`default_nettype none
interface otsu_pix_if import otsu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             last;
    modport source(output valid, pixel, last, input ready);
    modport sink(input valid, pixel, last, output ready);
endinterface

interface otsu_thr_if import otsu_pkg::*;;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] threshold;
    modport source(output valid, threshold, input ready);
    modport sink(input valid, threshold, output ready);
endinterface
`default_nettype wire

>>> rtl/otsu_hist.sv
// Histogram memory with a read-modify-write increment pipeline, one-deep
// forwarding for back-to-back hits, and walk reads with zero write-back.
// Depends on otsu_pkg.
`default_nettype none
module otsu_hist import otsu_pkg::*; #(
    parameter int GRAY_LEVELS      = GRAY_LEVELS_DEF,
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
    localparam int LB = $clog2(GRAY_LEVELS),
    localparam int CW = PIXEL_COUNT_BITS + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_hist_cmd     i_cmd,
    input  wire logic [LB-1:0] i_inc_addr,
    input  wire logic [LB-1:0] i_addr,
    output logic [CW-1:0]      o_rd_data,
    output logic               o_busy
);

    logic [CW-1:0] mem [GRAY_LEVELS];
    logic [CW-1:0] r_q;
    logic          r_s1_v;
    logic [LB-1:0] r_s1_addr;
    logic          r_wb_v;
    logic [LB-1:0] r_wb_addr;
    logic [CW-1:0] r_wb_data;
    logic [LB-1:0] rd_a;
    logic          w_en;
    logic [LB-1:0] w_addr;
    logic [CW-1:0] w_data;
    logic [CW-1:0] cur;

    assign rd_a = i_cmd.inc ? i_inc_addr : i_addr;
    assign cur  = (r_wb_v && (r_wb_addr == r_s1_addr)) ? r_wb_data : r_q;

    always_comb begin
        w_en   = 1'b0;
        w_addr = i_addr;
        w_data = '0;
        if (r_s1_v) begin
            w_en   = 1'b1;
            w_addr = r_s1_addr;
            w_data = cur + CW'(1);
        end else if (i_cmd.wz) begin
            w_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_q <= mem[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_wb_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.inc;
            r_wb_v <= r_s1_v;
        end
        r_s1_addr <= i_inc_addr;
        r_wb_addr <= r_s1_addr;
        r_wb_data <= cur + CW'(1);
    end

    assign o_rd_data = r_q;
    assign o_busy    = r_s1_v;

endmodule
`default_nettype wire

>>> rtl/otsu_mul.sv
// Shift-add multiplier, one bit of b per cycle; shared by all score math.
// Depends on otsu_pkg.
`default_nettype none
module otsu_mul import otsu_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic                  o_done,
    output logic [AW+BW-1:0]      o_p
);

    localparam int KW = $clog2(BW + 1);

    logic [AW+BW-1:0] r_acc;
    logic [AW+BW-1:0] r_a;
    logic [BW-1:0]    r_b;
    logic [KW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_acc <= '0;
            r_a   <= (AW+BW)'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule
`default_nettype wire

>>> rtl/otsu_threshold_select_core.sv
// Otsu threshold core: takes gray pixels, returns one threshold per image.
// Depends on otsu_pkg, otsu_if, otsu_hist, otsu_mul.
//
// Pixels are taken one per cycle, while the core is accumulating, into a
// GRAY_LEVELS-bin histogram held in a single-port-read RAM; the pixel marked
// last starts a walk over all bins. Each walk step reads a bin (and zeroes
// it), updates the running count and weighted sum, and for scored bins runs
// six products through one bit-serial multiplier, so the walk dominates the
// per-image latency. Scores are compared exactly by cross multiplication.
// After reset a clearing pass over all bins runs before the first pixel is
// taken. The threshold waits in an output register, so the next image can
// stream in while it is unclaimed.
`default_nettype none
module otsu_threshold_select_core import otsu_pkg::*; #(
    parameter int GRAY_LEVELS      = GRAY_LEVELS_DEF,
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    otsu_pix_if.sink  i_pix,
    otsu_thr_if.source o_thr
);

    localparam int LB  = $clog2(GRAY_LEVELS);
    localparam int CW  = PIXEL_COUNT_BITS + 1;
    localparam int MW  = CW + LB;
    localparam int DW  = MW + CW;
    localparam int D2W = 2 * DW;
    localparam int BW  = 2 * CW;
    localparam int XW  = D2W + BW;
    localparam int PW  = D2W + DW;
    localparam logic [CW-1:0] LIMIT = {1'b1, {PIXEL_COUNT_BITS{1'b0}}};
    localparam logic [LB-1:0] TOP   = LB'(GRAY_LEVELS - 1);

    t_state         r_state, n_state;
    t_op            r_op;
    t_hist_cmd      cmd;
    logic [LB-1:0]  r_t;
    logic [CW-1:0]  r_n;
    logic [MW-1:0]  r_mt;
    logic [CW-1:0]  r_w;
    logic [MW-1:0]  r_m;
    logic [MW-1:0]  r_th;
    logic [DW-1:0]  r_t1;
    logic [DW-1:0]  r_d;
    logic [D2W-1:0] r_d2;
    logic [BW-1:0]  r_b;
    logic [XW-1:0]  r_x1;
    logic [D2W-1:0] r_bd2;
    logic [BW-1:0]  r_bb;
    logic [LB-1:0]  r_best;
    logic           r_out_v;
    logic [THR_W-1:0] r_out_thr;

    logic           acc;
    logic           cnt_ok;
    logic [LB-1:0]  lvl;
    logic [CW-1:0]  hist_q;
    logic           hist_busy;
    logic           mul_start;
    logic           mul_done;
    logic [D2W-1:0] mul_a;
    logic [DW-1:0]  mul_b;
    logic [PW-1:0]  prod;
    logic           skip;
    logic           out_load;

    assign acc    = i_pix.valid && i_pix.ready;
    assign cnt_ok = (r_n != LIMIT);
    assign lvl    = (32'(i_pix.pixel) > 32'(GRAY_LEVELS - 1)) ? TOP : LB'(i_pix.pixel);
    assign skip   = (r_w == '0) || (r_w == r_n);

    assign cmd.inc = acc && cnt_ok;
    assign cmd.wz  = (r_state == ST_RD) || (r_state == ST_CLEAR);
    assign mul_start = (r_state == ST_MSTART);
    assign out_load  = (r_state == ST_OUT) && (!r_out_v || o_thr.ready);

    otsu_hist #(
        .GRAY_LEVELS      (GRAY_LEVELS),
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_inc_addr (lvl),
        .i_addr     (r_t),
        .o_rd_data  (hist_q),
        .o_busy     (hist_busy)
    );

    always_comb begin
        unique case (r_op)
            OP_MW: begin
                mul_a = D2W'(r_mt);
                mul_b = DW'(r_w);
            end
            OP_MN: begin
                mul_a = D2W'(r_m);
                mul_b = DW'(r_n);
            end
            OP_DD: begin
                mul_a = D2W'(r_d);
                mul_b = r_d;
            end
            OP_WB: begin
                mul_a = D2W'(r_w);
                mul_b = DW'(r_n - r_w);
            end
            OP_X1: begin
                mul_a = r_d2;
                mul_b = DW'(r_bb);
            end
            default: begin
                mul_a = r_bd2;
                mul_b = DW'(r_b);
            end
        endcase
    end

    otsu_mul #(
        .AW (D2W),
        .BW (DW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (prod)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_t == TOP) n_state = ST_ACC;
            ST_ACC:    if (acc && i_pix.last) n_state = ST_DRAIN;
            ST_DRAIN:  if (!hist_busy) n_state = ST_RD;
            ST_RD:     n_state = ST_HV;
            ST_HV:     n_state = ST_MADD;
            ST_MADD: begin
                if (r_t == TOP) begin
                    n_state = ST_OUT;
                end else if (skip) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_MSTART;
                end
            end
            ST_MSTART: n_state = ST_MWAIT;
            ST_MWAIT: begin
                if (mul_done) begin
                    n_state = (r_op == OP_X2) ? ST_RD : ST_MSTART;
                end
            end
            ST_OUT:    if (out_load) n_state = ST_ACC;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_t     <= '0;
            r_op    <= OP_MW;
            r_n     <= '0;
            r_mt    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_thr.valid && o_thr.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: r_t <= (r_t == TOP) ? '0 : r_t + LB'(1);
                ST_ACC: begin
                    if (cmd.inc) begin
                        r_n  <= r_n + CW'(1);
                        r_mt <= r_mt + MW'(lvl);
                    end
                    if (acc && i_pix.last) begin
                        r_t <= '0;
                    end
                end
                ST_MADD: begin
                    r_op <= OP_MW;
                    if (r_t != TOP && skip) begin
                        r_t <= r_t + LB'(1);
                    end
                end
                ST_MWAIT: begin
                    if (mul_done) begin
                        unique case (r_op)
                            OP_MW:   r_op <= OP_MN;
                            OP_MN:   r_op <= OP_DD;
                            OP_DD:   r_op <= OP_WB;
                            OP_WB:   r_op <= OP_X1;
                            OP_X1:   r_op <= OP_X2;
                            default: r_t  <= r_t + LB'(1);
                        endcase
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_out_v <= 1'b1;
                        r_n     <= '0;
                        r_mt    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ACC && acc && i_pix.last) begin
            r_w    <= '0;
            r_m    <= '0;
            r_bd2  <= '0;
            r_bb   <= BW'(1);
            r_best <= '0;
        end
        if (r_state == ST_HV) begin
            r_w  <= r_w + hist_q;
            r_th <= MW'(r_t) * MW'(hist_q);
        end
        if (r_state == ST_MADD) begin
            r_m <= r_m + r_th;
        end
        if (r_state == ST_MWAIT && mul_done) begin
            unique case (r_op)
                OP_MW: r_t1 <= prod[DW-1:0];
                OP_MN: r_d  <= (r_t1 >= prod[DW-1:0]) ? r_t1 - prod[DW-1:0]
                                                      : prod[DW-1:0] - r_t1;
                OP_DD: r_d2 <= prod[D2W-1:0];
                OP_WB: r_b  <= prod[BW-1:0];
                OP_X1: r_x1 <= prod[XW-1:0];
                default: begin
                    if (r_x1 > prod[XW-1:0]) begin
                        r_bd2  <= r_d2;
                        r_bb   <= r_b;
                        r_best <= r_t;
                    end
                end
            endcase
        end
        if (out_load) begin
            r_out_thr <= THR_W'(r_best);
        end
    end

    assign i_pix.ready     = (r_state == ST_ACC);
    assign o_thr.valid     = r_out_v;
    assign o_thr.threshold = r_out_thr;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= LIMIT)
        else $error("pixel count past limit");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_best != TOP))
        else $error("best bin out of scored range");

    a_walk_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> !hist_busy)
        else $error("walk read while increment pending");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_thr.valid) |-> ($past(r_state) == ST_OUT))
        else $error("threshold beat without a finished walk");

endmodule
`default_nettype wire

>>> tb/otsu_threshold_select_core_tb.sv
// Testbench for otsu_threshold_select_core: streams images of gray pixels and
// checks each threshold against an exact integer Otsu predictor.
// Depends on otsu_pkg, otsu_if and the core.
`timescale 1ns / 100ps
module otsu_threshold_select_core_tb;
    import otsu_pkg::*;

    localparam int LEVELS     = GRAY_LEVELS_DEF;
    localparam int CNT_BITS   = PIXEL_COUNT_BITS_DEF;
    localparam int STALL_LIM  = 400000;
    localparam int HOLD_LEN   = 20000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             last;
        int               src_pct;
        int               dst_pct;
        bit               hold_rx;
        bit               drain;
    } t_pix_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    otsu_pix_if pix ();
    otsu_thr_if thr ();

    otsu_threshold_select_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix.sink),
        .o_thr  (thr.source)
    );

    t_pix_beat         pend_q[$];
    logic [THR_W-1:0]  thr_exp_q[$];
    longint unsigned   hist[LEVELS];
    longint unsigned   pix_cnt;
    longint unsigned   lvl_sum;
    int                errors = 0;
    int                dst_pct = 0;
    int                hold_seq = 0;
    int                hold_seen = 0;
    int                hold_cnt = 0;
    int                idle_cycles = 0;
    logic              pix_fire = 1'b0;
    bit                rst_done = 0;

    function automatic logic [THR_W-1:0] otsu_pick();
        logic [255:0] w, m, n, tot, a, b, d2, den, best_d2, best_den;
        int best;
        w = 0; m = 0; n = pix_cnt; tot = lvl_sum;
        best_d2 = 0; best_den = 1; best = 0;
        for (int t = 0; t < LEVELS - 1; t++) begin
            w = w + hist[t];
            m = m + t * hist[t];
            if (w == 0 || w == n) continue;
            a = tot * w;
            b = m * n;
            d2 = (a >= b) ? a - b : b - a;
            d2 = d2 * d2;
            den = w * (n - w);
            if (d2 * best_den > best_d2 * den) begin
                best_d2 = d2;
                best_den = den;
                best = t;
            end
        end
        return best[THR_W-1:0];
    endfunction

    task automatic add_pixel(input logic [PIX_W-1:0] p, input logic l);
        int lv;
        lv = (p > LEVELS - 1) ? LEVELS - 1 : p;
        if (pix_cnt < (64'd1 << CNT_BITS)) begin
            hist[lv]++;
            pix_cnt++;
            lvl_sum += lv;
        end
        if (l) begin
            thr_exp_q = {thr_exp_q, otsu_pick()};
            foreach (hist[i]) hist[i] = 0;
            pix_cnt = 0;
            lvl_sum = 0;
        end
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin
        pix_fire <= pix.valid && pix.ready;
        if (rst_done) begin
            if (pix.valid && pix.ready) add_pixel(pix.pixel, pix.last);
            if (thr.valid && thr.ready) begin
                if (thr_exp_q.size() == 0) begin
                    $display("%0t: unexpected threshold %0d", $time, thr.threshold);
                    errors++;
                end else begin
                    if (thr.threshold !== thr_exp_q[0]) begin
                        $display("%0t: threshold mismatch expected %0d actual %0d",
                                 $time, thr_exp_q[0], thr.threshold);
                        errors++;
                    end
                    void'(thr_exp_q.pop_front());
                end
            end
            if ((pix.valid && pix.ready) || (thr.valid && thr.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIM) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        if (!rst_done) begin
            pix.valid <= 1'b0;
        end else if (pix.valid && !pix_fire) begin
        end else if (pend_q.size() == 0 || (pend_q[0].drain && thr_exp_q.size() != 0)
                     || $urandom_range(0, 99) < pend_q[0].src_pct) begin
            pix.valid <= 1'b0;
        end else begin
            pix.pixel <= pend_q[0].pixel;
            pix.last  <= pend_q[0].last;
            pix.valid <= 1'b1;
            dst_pct   <= pend_q[0].dst_pct;
            if (pend_q[0].hold_rx) hold_seq <= hold_seq + 1;
            void'(pend_q.pop_front());
        end
    end

    // threshold receiver
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cnt  <= HOLD_LEN;
            thr.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            thr.ready <= 1'b0;
        end else begin
            thr.ready <= ($urandom_range(0, 99) >= dst_pct);
        end
    end

    task automatic push_pix(input int p, input bit l, input int sp, input int dp,
                            input bit hold = 0, input bit drain = 0);
        t_pix_beat b;
        b.pixel = PIX_W'(p); b.last = l; b.src_pct = sp; b.dst_pct = dp;
        b.hold_rx = hold; b.drain = drain;
        pend_q = {pend_q, b};
    endtask

    task automatic push_image(input int npix, input int base, input int span,
                              input int sp, input int dp);
        int p;
        for (int i = 0; i < npix; i++) begin
            p = base + $urandom_range(0, span);
            if (p > 255) p = 255;
            push_pix(p, i == npix - 1, sp, dp);
        end
    endtask

    initial begin
        int sp, dp, span, sent;
        pix.valid = 1'b0; pix.pixel = '0; pix.last = 1'b0;
        thr.ready = 1'b0;
        foreach (hist[i]) hist[i] = 0;
        pix_cnt = 0; lvl_sum = 0;

        // lone pixel, flat image, full-range extremes, tie between levels
        push_pix(255, 1, 0, 0);
        push_pix(0, 1, 0, 0);
        for (int i = 0; i < 4; i++) push_pix(77, i == 3, 0, 0);
        push_pix(0, 0, 0, 0); push_pix(255, 0, 0, 0); push_pix(170, 0, 0, 0);
        push_pix(85, 1, 0, 0);
        push_pix(10, 0, 0, 0); push_pix(20, 1, 0, 0);
        push_pix(100, 0, 0, 0); push_pix(100, 0, 0, 0); push_pix(101, 1, 0, 0);
        push_pix(254, 0, 0, 0); push_pix(1, 0, 0, 0); push_pix(128, 1, 0, 0);
        push_pix(3, 0, 0, 0); push_pix(5, 1, 0, 0, 0, 1);

        // receiver held off while three images queue up behind it
        push_pix(40, 0, 0, 0, 1); push_pix(45, 1, 0, 0);
        push_image(6, 60, 5, 0, 0);
        push_image(6, 200, 3, 0, 0);
        push_pix(9, 0, 0, 0, 0, 1); push_pix(12, 1, 0, 0);

        sent = 0;
        for (int img = 0; sent < 1100; img++) begin
            case ((img / 12) % 4)
                0: begin sp = 0;  dp = 0;  end
                1: begin sp = 74; dp = 0;  end
                2: begin sp = 0;  dp = 74; end
                default: begin sp = 33; dp = 33; end
            endcase
            span = ($urandom_range(0, 24) == 0) ? 255 : $urandom_range(0, 12);
            begin
                int npix;
                npix = $urandom_range(1, 40);
                push_image(npix, $urandom_range(0, 255 - (span == 255 ? 0 : span)),
                           span, sp, dp);
                sent += npix;
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1;
        wait (pend_q.size() == 0 && !pix.valid && thr_exp_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && thr_exp_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
